// ----- hw/rtl/wsbh_pkg.sv -----
// Shared types and field widths for the wrapped segment versus box hit test.
package wsbh_pkg;

  localparam int START_X_W = 11;
  localparam int START_Y_W = 10;
  localparam int DELTA_X_W = 12;
  localparam int DELTA_Y_W = 11;
  localparam int BOX_LEFT_W = 7;
  localparam int BOX_TOP_W = 6;
  localparam int BOX_WIDTH_W = 7;
  localparam int BOX_HEIGHT_W = 6;

  typedef struct packed {
    logic [START_X_W-1:0]           start_x;
    logic [START_Y_W-1:0]           start_y;
    logic signed [DELTA_X_W-1:0]    delta_x;
    logic signed [DELTA_Y_W-1:0]    delta_y;
    logic [BOX_LEFT_W-1:0]          box_left;
    logic [BOX_TOP_W-1:0]           box_top;
    logic [BOX_WIDTH_W-1:0]         box_width;
    logic [BOX_HEIGHT_W-1:0]        box_height;
  } wsbh_item_t;

endpackage

// ----- hw/rtl/wsbh_align.sv -----
// Box bounds, arena wrap alignment and overlap test, one registered stage.
module wsbh_align #(
  parameter int ARENA_PIXELS_WIDE = 128,
  parameter int ARENA_PIXELS_HIGH = 64,
  parameter int SUBPIXEL_STEPS = 16,
  parameter int CW = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   valid_i,
  input  wsbh_pkg::wsbh_item_t                   item_i,
  output logic                                   valid_o,
  output logic                                   miss_o,
  output logic signed [wsbh_pkg::DELTA_X_W-1:0]  dx_o,
  output logic signed [wsbh_pkg::DELTA_Y_W-1:0]  dy_o,
  output logic signed [CW-1:0]                   top_rel_o,
  output logic signed [CW-1:0]                   left_rel_o,
  output logic signed [CW-1:0]                   span_x_o,
  output logic signed [CW-1:0]                   span_y_o
);

  localparam logic signed [CW-1:0] SUB_C = CW'(SUBPIXEL_STEPS);
  localparam logic signed [CW-1:0] EXT_X_C = CW'(ARENA_PIXELS_WIDE * SUBPIXEL_STEPS);
  localparam logic signed [CW-1:0] EXT_Y_C = CW'(ARENA_PIXELS_HIGH * SUBPIXEL_STEPS);
  localparam logic signed [CW-1:0] ONE_C = CW'(1);

  logic signed [CW-1:0] x_s, y_s, ex_s, ey_s;
  logic signed [CW-1:0] minx, maxx, miny, maxy;
  logic signed [CW-1:0] left0, right0, top0, bottom0;
  logic signed [CW-1:0] left, right, top, bottom;
  logic signed [CW-1:0] span_x, span_y;
  logic                 over_x, over_y;

  logic                                  valid_r;
  logic                                  miss_r, miss_nxt;
  logic signed [wsbh_pkg::DELTA_X_W-1:0] dx_r;
  logic signed [wsbh_pkg::DELTA_Y_W-1:0] dy_r;
  logic signed [CW-1:0]                  top_rel_r, top_rel_nxt;
  logic signed [CW-1:0]                  left_rel_r, left_rel_nxt;
  logic signed [CW-1:0]                  span_x_r, span_y_r;

  always_comb begin
    x_s = CW'($signed({1'b0, item_i.start_x}));
    y_s = CW'($signed({1'b0, item_i.start_y}));
    ex_s = x_s + CW'(item_i.delta_x);
    ey_s = y_s + CW'(item_i.delta_y);
    minx = (x_s < ex_s) ? x_s : ex_s;
    maxx = (x_s > ex_s) ? x_s : ex_s;
    miny = (y_s < ey_s) ? y_s : ey_s;
    maxy = (y_s > ey_s) ? y_s : ey_s;

    span_x = CW'($signed({1'b0, item_i.box_width})) * SUB_C - ONE_C;
    span_y = CW'($signed({1'b0, item_i.box_height})) * SUB_C - ONE_C;
    left0 = CW'($signed({1'b0, item_i.box_left})) * SUB_C;
    top0 = CW'($signed({1'b0, item_i.box_top})) * SUB_C;
    right0 = left0 + span_x;
    bottom0 = top0 + span_y;

    // Shift the box one arena extent toward the segment when it lies wholly past it.
    if (maxx < left0) begin
      left = left0 - EXT_X_C;
    end else if (minx > right0) begin
      left = left0 + EXT_X_C;
    end else begin
      left = left0;
    end
    right = left + span_x;

    if (maxy < top0) begin
      top = top0 - EXT_Y_C;
    end else if (miny > bottom0) begin
      top = top0 + EXT_Y_C;
    end else begin
      top = top0;
    end
    bottom = top + span_y;

    over_x = !((maxx < left) || (minx > right));
    over_y = !((maxy < top) || (miny > bottom));

    miss_nxt = (item_i.box_width == '0) || (item_i.box_height == '0) || !over_x || !over_y;
    top_rel_nxt = top - y_s;
    left_rel_nxt = left - x_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    miss_r <= miss_nxt;
    dx_r <= item_i.delta_x;
    dy_r <= item_i.delta_y;
    top_rel_r <= top_rel_nxt;
    left_rel_r <= left_rel_nxt;
    span_x_r <= span_x;
    span_y_r <= span_y;
  end

  assign valid_o = valid_r;
  assign miss_o = miss_r;
  assign dx_o = dx_r;
  assign dy_o = dy_r;
  assign top_rel_o = top_rel_r;
  assign left_rel_o = left_rel_r;
  assign span_x_o = span_x_r;
  assign span_y_o = span_y_r;

endmodule

// ----- hw/rtl/wsbh_cross.sv -----
// Corner cross products and the sign test that decides the hit flag.
module wsbh_cross #(
  parameter int CW = 16,
  parameter int PW = 30
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  valid_i,
  input  logic                                  miss_i,
  input  logic signed [wsbh_pkg::DELTA_X_W-1:0] dx_i,
  input  logic signed [wsbh_pkg::DELTA_Y_W-1:0] dy_i,
  input  logic signed [CW-1:0]                  top_rel_i,
  input  logic signed [CW-1:0]                  left_rel_i,
  input  logic signed [CW-1:0]                  span_x_i,
  input  logic signed [CW-1:0]                  span_y_i,
  output logic                                  valid_o,
  output logic                                  hit_o
);

  logic signed [PW-1:0] pa_r, pa_nxt, pb_r, pb_nxt, pc_r, pc_nxt, pd_r, pd_nxt;
  logic                 miss_r;
  logic                 prod_valid_r;
  logic signed [PW-1:0] tl, tr, bl, br;
  logic                 all_pos, all_neg;
  logic                 hit_r, hit_nxt;
  logic                 valid_r;

  // Four products per item, each registered before the sums.
  always_comb begin
    pa_nxt = PW'(dx_i) * PW'(top_rel_i);
    pb_nxt = PW'(dy_i) * PW'(left_rel_i);
    pc_nxt = PW'(dy_i) * PW'(span_x_i);
    pd_nxt = PW'(dx_i) * PW'(span_y_i);
  end

  always_comb begin
    tl = pa_r - pb_r;
    tr = tl - pc_r;
    bl = tl + pd_r;
    br = tr + pd_r;
    all_pos = !tl[PW-1] && (tl != '0) && !tr[PW-1] && (tr != '0) &&
              !bl[PW-1] && (bl != '0) && !br[PW-1] && (br != '0);
    all_neg = tl[PW-1] && tr[PW-1] && bl[PW-1] && br[PW-1];
    hit_nxt = !miss_r && !all_pos && !all_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      prod_valid_r <= valid_i;
      valid_r <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
    pc_r <= pc_nxt;
    pd_r <= pd_nxt;
    miss_r <= miss_i;
    hit_r <= hit_nxt;
  end

  assign valid_o = valid_r;
  assign hit_o = hit_r;

endmodule

// ----- hw/rtl/wrapped_segment_box_hit.sv -----
// Top level of the segment versus box hit test on a wrapping arena.
// Throughput: one transaction per cycle; busy stays low, start is taken every cycle.
// The four stages are the input register, alignment, the products and the sign test.
// Reset clears only the valid flags of the stages; the receiver cannot stall.
// out_valid is a one-cycle strobe and out_hit is meaningful only while it is high.
module wrapped_segment_box_hit #(
  parameter int ARENA_PIXELS_WIDE = 128,
  parameter int ARENA_PIXELS_HIGH = 64,
  parameter int SUBPIXEL_STEPS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [wsbh_pkg::START_X_W-1:0]        in_start_x,
  input  logic [wsbh_pkg::START_Y_W-1:0]        in_start_y,
  input  logic signed [wsbh_pkg::DELTA_X_W-1:0] in_delta_x,
  input  logic signed [wsbh_pkg::DELTA_Y_W-1:0] in_delta_y,
  input  logic [wsbh_pkg::BOX_LEFT_W-1:0]       in_box_left,
  input  logic [wsbh_pkg::BOX_TOP_W-1:0]        in_box_top,
  input  logic [wsbh_pkg::BOX_WIDTH_W-1:0]      in_box_width,
  input  logic [wsbh_pkg::BOX_HEIGHT_W-1:0]     in_box_height,
  output logic                                  out_valid,
  output logic                                  out_hit
);

  // Coordinate width covers the box, one arena shift and the unwrapped segment end,
  // with headroom for the differences taken against the segment start.
  localparam int CW = $clog2((256 + ARENA_PIXELS_WIDE + ARENA_PIXELS_HIGH) *
                             SUBPIXEL_STEPS + 4096) + 2;
  // Product width holds a delta times a coordinate plus the growth of three sums.
  localparam int PW = CW + 14;

  logic                                  in_valid_r;
  wsbh_pkg::wsbh_item_t                  item_r, item_nxt;

  logic                                  al_valid, al_miss;
  logic signed [wsbh_pkg::DELTA_X_W-1:0] al_dx;
  logic signed [wsbh_pkg::DELTA_Y_W-1:0] al_dy;
  logic signed [CW-1:0]                  al_top_rel, al_left_rel, al_span_x, al_span_y;

  // Every cycle can take a new transaction, so the block never reports busy.
  assign busy = 1'b0;

  always_comb begin
    item_nxt.start_x = in_start_x;
    item_nxt.start_y = in_start_y;
    item_nxt.delta_x = in_delta_x;
    item_nxt.delta_y = in_delta_y;
    item_nxt.box_left = in_box_left;
    item_nxt.box_top = in_box_top;
    item_nxt.box_width = in_box_width;
    item_nxt.box_height = in_box_height;
  end

  // Input register: the valid flag is reset, the payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  // Second stage: box bounds, arena alignment and the overlap check.
  wsbh_align #(
    .ARENA_PIXELS_WIDE (ARENA_PIXELS_WIDE),
    .ARENA_PIXELS_HIGH (ARENA_PIXELS_HIGH),
    .SUBPIXEL_STEPS    (SUBPIXEL_STEPS),
    .CW                (CW)
  ) u_align (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (in_valid_r),
    .item_i     (item_r),
    .valid_o    (al_valid),
    .miss_o     (al_miss),
    .dx_o       (al_dx),
    .dy_o       (al_dy),
    .top_rel_o  (al_top_rel),
    .left_rel_o (al_left_rel),
    .span_x_o   (al_span_x),
    .span_y_o   (al_span_y)
  );

  // Third and fourth stages: corner cross products, then the sign decision.
  wsbh_cross #(
    .CW (CW),
    .PW (PW)
  ) u_cross (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (al_valid),
    .miss_i     (al_miss),
    .dx_i       (al_dx),
    .dy_i       (al_dy),
    .top_rel_i  (al_top_rel),
    .left_rel_i (al_left_rel),
    .span_x_i   (al_span_x),
    .span_y_i   (al_span_y),
    .valid_o    (out_valid),
    .hit_o      (out_hit)
  );

  // A result strobe always traces back to an accepted transaction.
  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result strobe without a matching transaction");

  // Every accepted transaction gives its result strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted transaction lost in the pipeline");

  // An empty box can never be hit.
  a_empty_box_misses: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_box_width == '0) || (in_box_height == '0)))
      |-> ##4 (out_valid && !out_hit))
    else $error("hit reported for an empty box");

endmodule
